>>> sv/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 128;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths of the item channels
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned TOTAL_W = 8;
  localparam int unsigned STAT_W  = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_DN_L,
    S_DN_R,
    S_PUT,
    S_DONE
  } state_t;

  // One result item
  typedef struct packed {
    logic signed [WORD_W-1:0]  top_value;
    logic signed [WORD_W-1:0]  removed_value;
    logic        [TOTAL_W-1:0] element_total;
    status_t                   status;
  } result_t;

endpackage

>>> sv/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mhpq_obuf.sv
// One-entry output register for result items.
module mhpq_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mhpq_pkg::result_t    load_data,
  output logic                 can_load,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output mhpq_pkg::result_t    rsp_data
);

  logic full;

  // Room when empty or when the held item leaves this cycle
  assign can_load  = !full || !rsp_stall;
  assign rsp_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!rsp_stall) begin
      full <= 1'b0;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= load_data;
    end
  end

endmodule

>>> sv/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: sequencer around the heap RAM.
// Usage:
//   Request channel: req_valid/req_stall with operation (0 insert, 1 remove
//   the maximum) and value. An item is taken when req_valid is high and
//   req_stall is low. req_stall is high while an item is being worked on.
//   Response channel: rsp_valid/rsp_stall with top_value, removed_value,
//   element_total and status; exactly one result item per request item.
// Sequencing:
//   The heap lives in one RAM with one write and one registered read port.
//   An insert sifts up one level per cycle. A removal reads the last entry
//   and sifts down, reading left and right child in separate cycles.
//   Refused items go straight to the result. Items are processed one at
//   a time.
// Reset:
//   rst (synchronous, active high) empties the heap at once; no clearing
//   pass is needed since only entries below the count are ever read.
// Stall:
//   A finished result sits in an output register; the next request is
//   taken meanwhile, and the sequencer only waits at its end if that
//   register is still occupied.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY   = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = mhpq_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                operation,
  input  logic signed [mhpq_pkg::WORD_W-1:0]  value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [mhpq_pkg::WORD_W-1:0]  top_value,
  output logic signed [mhpq_pkg::WORD_W-1:0]  removed_value,
  output logic        [mhpq_pkg::TOTAL_W-1:0] element_total,
  output logic        [mhpq_pkg::STAT_W-1:0]  status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned AW = $clog2(CAPACITY);

  mhpq_pkg::state_t  state, state_next;
  mhpq_pkg::status_t stat, stat_next;

  logic        [CW-1:0]         count, count_next;
  logic        [IW-1:0]         idx, idx_next;
  logic        [IW-1:0]         best_idx, best_idx_next;
  logic signed [VALUE_BITS-1:0] hold, hold_next;
  logic signed [VALUE_BITS-1:0] best_val, best_val_next;
  logic signed [VALUE_BITS-1:0] root;
  logic signed [VALUE_BITS-1:0] removed, removed_next;
  logic signed [VALUE_BITS-1:0] in_word;
  logic signed [VALUE_BITS-1:0] rd_word;

  // RAM access in 1-based heap indices
  logic                  we;
  logic [IW-1:0]         w_idx;
  logic [VALUE_BITS-1:0] w_data;
  logic [IW-1:0]         r_idx;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Sift-down candidate and child indices
  logic [IW-1:0]         left, right, cand_idx, cand_child, count_ext;
  logic signed [VALUE_BITS-1:0] cand_val;

  // Output side
  logic                load;
  logic                can_load;
  mhpq_pkg::result_t   res, rsp_data;

  assign in_word   = VALUE_BITS'(value);
  assign rd_word   = ram_rdata;
  assign count_ext = IW'(count);
  assign left      = {idx[IW-2:0], 1'b0};
  assign right     = {idx[IW-2:0], 1'b1};
  assign req_stall = (state != mhpq_pkg::S_IDLE);

  mhpq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(w_idx - IW'(1))),
    .wdata (w_data),
    .raddr (AW'(r_idx - IW'(1))),
    .rdata (ram_rdata)
  );

  // Larger of element and children seen so far
  always_comb begin
    cand_idx = best_idx;
    cand_val = best_val;
    if (state == mhpq_pkg::S_DN_L) begin
      if (rd_word > hold) begin
        cand_idx = left;
        cand_val = rd_word;
      end else begin
        cand_idx = idx;
        cand_val = hold;
      end
    end else if (rd_word > best_val) begin
      cand_idx = right;
      cand_val = rd_word;
    end
    cand_child = {cand_idx[IW-2:0], 1'b0};
  end

  // Sequencer: next state, RAM accesses, register updates
  always_comb begin
    state_next    = state;
    stat_next     = stat;
    count_next    = count;
    idx_next      = idx;
    best_idx_next = best_idx;
    best_val_next = best_val;
    hold_next     = hold;
    removed_next  = removed;
    we            = 1'b0;
    w_idx         = idx;
    w_data        = hold;
    r_idx         = idx;
    load          = 1'b0;

    unique case (state)
      mhpq_pkg::S_IDLE: begin
        if (req_valid) begin
          removed_next = '0;
          stat_next    = mhpq_pkg::ST_OK;
          state_next   = mhpq_pkg::S_DONE;
          if (operation == mhpq_pkg::OP_INSERT) begin
            if (count_ext == IW'(CAPACITY)) begin
              stat_next = mhpq_pkg::ST_OVERFLOW;
            end else begin
              count_next = CW'(count_ext + IW'(1));
              idx_next   = count_ext + IW'(1);
              hold_next  = in_word;
              if (count == '0) begin
                we     = 1'b1;
                w_idx  = IW'(1);
                w_data = in_word;
              end else begin
                r_idx      = (count_ext + IW'(1)) >> 1;
                state_next = mhpq_pkg::S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              stat_next = mhpq_pkg::ST_UNDERFLOW;
            end else begin
              removed_next = root;
              r_idx        = count_ext;
              count_next   = CW'(count_ext - IW'(1));
              state_next   = mhpq_pkg::S_LAST;
            end
          end
        end
      end

      // Parent data is in; move the parent down or settle here
      mhpq_pkg::S_UP: begin
        we = 1'b1;
        if (hold > rd_word) begin
          w_data   = rd_word;
          idx_next = idx >> 1;
          if ((idx >> 1) == IW'(1)) begin
            state_next = mhpq_pkg::S_PUT;
          end else begin
            r_idx = idx >> 2;
          end
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end

      // Last element is in; it starts its way down from the root
      mhpq_pkg::S_LAST: begin
        hold_next = rd_word;
        if (count == '0) begin
          state_next = mhpq_pkg::S_DONE;
        end else begin
          idx_next = IW'(1);
          if (IW'(2) <= count_ext) begin
            r_idx      = IW'(2);
            state_next = mhpq_pkg::S_DN_L;
          end else begin
            state_next = mhpq_pkg::S_PUT;
          end
        end
      end

      mhpq_pkg::S_DN_L,
      mhpq_pkg::S_DN_R: begin
        best_idx_next = cand_idx;
        best_val_next = cand_val;
        if (state == mhpq_pkg::S_DN_L && right <= count_ext) begin
          r_idx      = right;
          state_next = mhpq_pkg::S_DN_R;
        end else if (cand_idx == idx) begin
          we         = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          // Larger child moves up into the hole
          we       = 1'b1;
          w_data   = cand_val;
          idx_next = cand_idx;
          if (cand_child <= count_ext) begin
            r_idx      = cand_child;
            state_next = mhpq_pkg::S_DN_L;
          end else begin
            state_next = mhpq_pkg::S_PUT;
          end
        end
      end

      mhpq_pkg::S_PUT: begin
        we         = 1'b1;
        state_next = mhpq_pkg::S_DONE;
      end

      mhpq_pkg::S_DONE: begin
        if (can_load) begin
          load       = 1'b1;
          state_next = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Datapath registers; root mirrors heap entry 1
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    best_idx <= best_idx_next;
    best_val <= best_val_next;
    hold     <= hold_next;
    removed  <= removed_next;
    stat     <= stat_next;
    if (we && w_idx == IW'(1)) begin
      root <= w_data;
    end
  end

  // Result item
  always_comb begin
    res.top_value     = (count != '0) ? mhpq_pkg::WORD_W'(root) : '0;
    res.removed_value = mhpq_pkg::WORD_W'(removed);
    res.element_total = mhpq_pkg::TOTAL_W'(count);
    res.status        = stat;
  end

  mhpq_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (res),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  assign top_value     = rsp_data.top_value;
  assign removed_value = rsp_data.removed_value;
  assign element_total = rsp_data.element_total;
  assign status        = rsp_data.status;

endmodule
